@@ hdl/mlr_pkg.sv @@
// ----------------------------------------------------------------------------
// mlr_pkg: shared definitions for the midpoint line rasterizer
// Operation codes, octant codes, register indexes, reset values and the
// status group passed from the core to the top level.
// ----------------------------------------------------------------------------
package mlr_pkg;

  // default coordinate width of target points and screen offsets
  localparam int COORD_BITS_DEF = 12;

  // configuration reset values
  localparam int CENTER_X_RESET = 320;
  localparam int CENTER_Y_RESET = 240;

  // configuration address: two 32-bit registers at byte addresses 0 and 4
  localparam int CFG_ADDR_BITS = 3;
  localparam int CFG_DATA_BITS = 32;

  typedef enum logic [0:0] {
    REG_CENTER_X = 1'b0,
    REG_CENTER_Y = 1'b1
  } reg_idx_t;

  // command codes on the input channel
  typedef enum logic [1:0] {
    OP_MOVE = 2'd0,
    OP_LINE = 2'd1,
    OP_TICK = 2'd2
  } op_t;

  // octant of the current line, counter-clockwise from the positive x axis
  typedef enum logic [2:0] {
    OCT_0 = 3'd0,
    OCT_1 = 3'd1,
    OCT_2 = 3'd2,
    OCT_3 = 3'd3,
    OCT_4 = 3'd4,
    OCT_5 = 3'd5,
    OCT_6 = 3'd6,
    OCT_7 = 3'd7
  } octant_t;

  // status of one processed word
  typedef struct packed {
    logic valid;       // the word produces a result
    logic last_pixel;  // final pixel of the line
    logic refused;     // command arrived while drawing
    logic drawing;     // a line walk is in progress
  } res_flags_t;

endpackage

@@ hdl/mlr_if.sv @@
// ----------------------------------------------------------------------------
// mlr_in_if / mlr_out_if: valid-ready channels of the line rasterizer
// Command words come in on mlr_in_if, pixel words leave on mlr_out_if.
// ----------------------------------------------------------------------------
interface mlr_in_if import mlr_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic [1:0]                   operation;
  logic signed [COORD_BITS-1:0] target_x;
  logic signed [COORD_BITS-1:0] target_y;

  modport source (output valid, output operation, output target_x, output target_y,
                  input ready);
  modport sink   (input valid, input operation, input target_x, input target_y,
                  output ready);
endinterface

interface mlr_out_if import mlr_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS+1:0] pixel_x;
  logic signed [COORD_BITS+1:0] pixel_y;
  logic                         last_pixel;
  logic                         refused;

  modport source (output valid, output pixel_x, output pixel_y, output last_pixel,
                  output refused, input ready);
  modport sink   (input valid, input pixel_x, input pixel_y, input last_pixel,
                  input refused, output ready);
endinterface

@@ hdl/midpoint_line_rasterizer_top.sv @@
// ----------------------------------------------------------------------------
// midpoint_line_rasterizer_top: pen-style midpoint line drawer
// Input register, command core and result register with APB configuration.
// ----------------------------------------------------------------------------
// A move word sets the pen, a line word loads the line from pen to target and
// moves the pen there, and each tick word then yields one screen pixel with a
// last flag on the final one (the endpoint is not drawn). The block takes one
// word per clock while the result register is free or being taken; a word
// passes through the input register and then the result register. The rate is
// set by the update of the walk and decision registers in the core; a stalled
// result holds the input register and drops in_ch.ready.
// Move and line words while a line is still being drawn come back as a
// refused result; idle ticks, and moves or lines while idle, return nothing.
// ----------------------------------------------------------------------------
module midpoint_line_rasterizer_top import mlr_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  mlr_in_if.sink                   in_ch,
  mlr_out_if.source                out_ch,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [CFG_ADDR_BITS-1:0] paddr,
  input  logic [CFG_DATA_BITS-1:0] pwdata,
  output logic [CFG_DATA_BITS-1:0] prdata,
  output logic                     pready
);

  localparam int P = COORD_BITS + 2;

  logic [COORD_BITS-1:0] center_x, center_y;

  // input register
  logic                         inq_valid_r, inq_valid_nxt;
  logic [1:0]                   op_r;
  logic signed [COORD_BITS-1:0] tx_r, ty_r;
  logic                         in_fire, proc_fire;

  // result register
  logic                out_valid_r, out_valid_nxt;
  logic signed [P-1:0] pixel_x_r, pixel_y_r;
  logic                last_r, refused_r;

  res_flags_t          core_flags;
  logic signed [P-1:0] core_px, core_py;

  mlr_cfg_regs #(
    .COORD_BITS (COORD_BITS)
  ) u_cfg_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .center_x (center_x),
    .center_y (center_y)
  );

  // advance the held word when the result slot frees up
  assign proc_fire   = inq_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !inq_valid_r || proc_fire;
  assign in_fire     = in_ch.valid && in_ch.ready;

  always_comb begin
    inq_valid_nxt = inq_valid_r;
    if (in_fire)        inq_valid_nxt = 1'b1;
    else if (proc_fire) inq_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inq_valid_r <= 1'b0;
    end else begin
      inq_valid_r <= inq_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r <= in_ch.operation;
      tx_r <= in_ch.target_x;
      ty_r <= in_ch.target_y;
    end
  end

  mlr_core #(
    .COORD_BITS (COORD_BITS)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .fire     (proc_fire),
    .op       (op_r),
    .tx       (tx_r),
    .ty       (ty_r),
    .center_x (center_x),
    .center_y (center_y),
    .flags    (core_flags),
    .pixel_x  (core_px),
    .pixel_y  (core_py)
  );

  // load the result slot, or drain it when taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (proc_fire)         out_valid_nxt = core_flags.valid;
    else if (out_ch.ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (proc_fire) begin
      pixel_x_r <= core_px;
      pixel_y_r <= core_py;
      last_r    <= core_flags.last_pixel;
      refused_r <= core_flags.refused;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.pixel_x    = pixel_x_r;
  assign out_ch.pixel_y    = pixel_y_r;
  assign out_ch.last_pixel = last_r;
  assign out_ch.refused    = refused_r;

  // a refused word carries no pixel and no last flag
  a_refused_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && refused_r |-> (pixel_x_r == '0) && (pixel_y_r == '0) && !last_r)
    else $error("refused word with pixel data");

  // a result only comes from a word that found a line in progress
  a_result_needs_line: assert property (@(posedge clk) disable iff (!rst_n)
    proc_fire && core_flags.valid |-> core_flags.drawing)
    else $error("result without a line in progress");

  // the last pixel ends the line
  a_last_ends_line: assert property (@(posedge clk) disable iff (!rst_n)
    proc_fire && core_flags.last_pixel |=> !core_flags.drawing)
    else $error("line still drawing after its last pixel");

  // a held word stays until the core takes it
  a_inq_holds: assert property (@(posedge clk) disable iff (!rst_n)
    inq_valid_r && !proc_fire |=> inq_valid_r && $stable(op_r) && $stable(tx_r))
    else $error("input word lost before processing");

endmodule

@@ hdl/mlr_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// mlr_cfg_regs: configuration registers
// APB-style slave holding the screen position of the logical origin.
// ----------------------------------------------------------------------------
module mlr_cfg_regs import mlr_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [CFG_ADDR_BITS-1:0] paddr,
  input  logic [CFG_DATA_BITS-1:0] pwdata,
  output logic [CFG_DATA_BITS-1:0] prdata,
  output logic                     pready,
  output logic [COORD_BITS-1:0]    center_x,
  output logic [COORD_BITS-1:0]    center_y
);

  logic [COORD_BITS-1:0] center_x_r, center_x_nxt;
  logic [COORD_BITS-1:0] center_y_r, center_y_nxt;
  logic                  wr_en;
  reg_idx_t              reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = reg_idx_t'(paddr[CFG_ADDR_BITS-1:2]);

  // decode the write
  always_comb begin
    center_x_nxt = center_x_r;
    center_y_nxt = center_y_r;
    if (wr_en) begin
      unique case (reg_idx)
        REG_CENTER_X: center_x_nxt = pwdata[COORD_BITS-1:0];
        REG_CENTER_Y: center_y_nxt = pwdata[COORD_BITS-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r <= COORD_BITS'(CENTER_X_RESET);
      center_y_r <= COORD_BITS'(CENTER_Y_RESET);
    end else begin
      center_x_r <= center_x_nxt;
      center_y_r <= center_y_nxt;
    end
  end

  // read back, zero extended
  always_comb begin
    unique case (reg_idx)
      REG_CENTER_X: prdata = CFG_DATA_BITS'(center_x_r);
      REG_CENTER_Y: prdata = CFG_DATA_BITS'(center_y_r);
    endcase
  end

  assign center_x = center_x_r;
  assign center_y = center_y_r;

endmodule

@@ hdl/mlr_pixel_map.sv @@
// ----------------------------------------------------------------------------
// mlr_pixel_map: walk point to screen pixel
// Unfolds a first-octant walk point into logical coordinates, adds the
// origin column to x and subtracts logical y from the origin row.
// ----------------------------------------------------------------------------
module mlr_pixel_map import mlr_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  octant_t                      octant,
  input  logic signed [COORD_BITS:0]   walk_x,
  input  logic signed [COORD_BITS:0]   walk_y,
  input  logic [COORD_BITS-1:0]        center_x,
  input  logic [COORD_BITS-1:0]        center_y,
  output logic signed [COORD_BITS+1:0] pixel_x,
  output logic signed [COORD_BITS+1:0] pixel_y
);

  localparam int P = COORD_BITS + 2;

  logic signed [P-1:0] fx, fy, lx, ly;

  assign fx = P'(walk_x);
  assign fy = P'(walk_y);

  // undo the fold for the line's octant
  always_comb begin
    unique case (octant)
      OCT_0: begin lx = fx;  ly = fy;  end
      OCT_1: begin lx = fy;  ly = fx;  end
      OCT_2: begin lx = -fy; ly = fx;  end
      OCT_3: begin lx = -fx; ly = fy;  end
      OCT_4: begin lx = -fx; ly = -fy; end
      OCT_5: begin lx = -fy; ly = -fx; end
      OCT_6: begin lx = fy;  ly = -fx; end
      OCT_7: begin lx = fx;  ly = -fy; end
    endcase
  end

  // screen offset, y flipped; wraps at the field width
  assign pixel_x = $signed({2'b00, center_x}) + lx;
  assign pixel_y = $signed({2'b00, center_y}) - ly;

endmodule

@@ hdl/mlr_core.sv @@
// ----------------------------------------------------------------------------
// mlr_core: pen and line walk state
// Handles move, line and tick commands: sets up the folded walk for a new
// line and advances the midpoint decision by one pixel per tick.
// ----------------------------------------------------------------------------
module mlr_core import mlr_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         fire,
  input  logic [1:0]                   op,
  input  logic signed [COORD_BITS-1:0] tx,
  input  logic signed [COORD_BITS-1:0] ty,
  input  logic [COORD_BITS-1:0]        center_x,
  input  logic [COORD_BITS-1:0]        center_y,
  output res_flags_t                   flags,
  output logic signed [COORD_BITS+1:0] pixel_x,
  output logic signed [COORD_BITS+1:0] pixel_y
);

  localparam int W = COORD_BITS + 1;  // walk coordinates
  localparam int P = COORD_BITS + 2;  // deltas and folded values
  localparam int S = COORD_BITS + 3;  // straight step
  localparam int D = COORD_BITS + 4;  // decision and diagonal step

  // state
  logic signed [COORD_BITS-1:0] pen_x_r, pen_x_nxt, pen_y_r, pen_y_nxt;
  logic                         drawing_r, drawing_nxt;
  octant_t                      octant_r, octant_nxt;
  logic signed [W-1:0]          walk_x_r, walk_x_nxt, walk_y_r, walk_y_nxt;
  logic signed [W-1:0]          end_x_r, end_x_nxt;
  logic signed [D-1:0]          decision_r, decision_nxt;
  logic signed [S-1:0]          straight_r, straight_nxt;
  logic signed [D-1:0]          diagonal_r, diagonal_nxt;

  // line setup
  logic signed [P-1:0] tx_e, ty_e, pen_x_e, pen_y_e;
  logic signed [P-1:0] dx, dy, ndx, ndy;
  octant_t             oct_pick;
  logic signed [P-1:0] fx1, fy1, fx2, a, b;
  logic signed [D-1:0] a_d, b_d, ab_d;

  // walk step
  logic signed [P-1:0] walk_x_inc;
  logic                last_cond;
  logic signed [P-1:0] px_raw, py_raw;
  logic                is_tick, is_cmd;

  function automatic logic signed [P-1:0] fold_x(octant_t oc, logic signed [P-1:0] x,
                                                 logic signed [P-1:0] y);
    unique case (oc)
      OCT_1, OCT_2: fold_x = y;
      OCT_3, OCT_4: fold_x = -x;
      OCT_5, OCT_6: fold_x = -y;
      OCT_0, OCT_7: fold_x = x;
    endcase
  endfunction

  function automatic logic signed [P-1:0] fold_y(octant_t oc, logic signed [P-1:0] x,
                                                 logic signed [P-1:0] y);
    unique case (oc)
      OCT_1, OCT_6: fold_y = x;
      OCT_2, OCT_5: fold_y = -x;
      OCT_4, OCT_7: fold_y = -y;
      OCT_0, OCT_3: fold_y = y;
    endcase
  endfunction

  assign tx_e    = P'(tx);
  assign ty_e    = P'(ty);
  assign pen_x_e = P'(pen_x_r);
  assign pen_y_e = P'(pen_y_r);
  assign dx      = tx_e - pen_x_e;
  assign dy      = ty_e - pen_y_e;
  assign ndx     = -dx;
  assign ndy     = -dy;

  // choose the octant by sign and magnitude; diagonals and axes tie as listed
  always_comb begin
    priority if (dy > 0) begin
      if (dx > 0) oct_pick = (dy >= dx) ? OCT_1 : OCT_0;
      else        oct_pick = (dy > ndx) ? OCT_2 : OCT_3;
    end else if (dy == 0) begin
      oct_pick = (dx < 0) ? OCT_4 : OCT_0;
    end else if (dx > 0) begin
      oct_pick = (ndy >= dx) ? OCT_6 : OCT_7;
    end else begin
      oct_pick = (dy >= dx) ? OCT_4 : OCT_5;
    end
  end

  // fold start, end and deltas into the first octant
  assign fx1  = fold_x(oct_pick, pen_x_e, pen_y_e);
  assign fy1  = fold_y(oct_pick, pen_x_e, pen_y_e);
  assign fx2  = fold_x(oct_pick, tx_e, ty_e);
  assign b    = fold_x(oct_pick, dx, dy);
  assign a    = fold_y(oct_pick, dx, dy);
  assign a_d  = D'(a);
  assign b_d  = D'(b);
  assign ab_d = a_d - b_d;

  // end of walk: the endpoint itself is not drawn
  assign walk_x_inc = P'(walk_x_r) + P'(1);
  assign last_cond  = (walk_x_inc >= P'(end_x_r));

  assign is_tick = (op == OP_TICK);
  assign is_cmd  = (op == OP_MOVE) || (op == OP_LINE);

  // next state
  always_comb begin
    pen_x_nxt    = pen_x_r;
    pen_y_nxt    = pen_y_r;
    drawing_nxt  = drawing_r;
    octant_nxt   = octant_r;
    walk_x_nxt   = walk_x_r;
    walk_y_nxt   = walk_y_r;
    end_x_nxt    = end_x_r;
    decision_nxt = decision_r;
    straight_nxt = straight_r;
    diagonal_nxt = diagonal_r;
    if (fire) begin
      unique case (op)
        OP_TICK: begin
          if (drawing_r) begin
            if (!decision_r[D-1] && (decision_r != '0)) begin
              walk_y_nxt   = walk_y_r + W'(1);
              decision_nxt = decision_r + diagonal_r;
            end else begin
              decision_nxt = decision_r + D'(straight_r);
            end
            walk_x_nxt  = walk_x_inc[W-1:0];
            drawing_nxt = !last_cond;
          end
        end
        OP_MOVE, OP_LINE: begin
          if (!drawing_r) begin
            pen_x_nxt = tx;
            pen_y_nxt = ty;
            if (op == OP_LINE) begin
              octant_nxt   = oct_pick;
              walk_x_nxt   = fx1[W-1:0];
              walk_y_nxt   = fy1[W-1:0];
              end_x_nxt    = fx2[W-1:0];
              decision_nxt = a_d + a_d - b_d;
              straight_nxt = S'(a_d + a_d);
              diagonal_nxt = ab_d + ab_d;
              drawing_nxt  = (fx1 < fx2);
            end
          end
        end
        default: begin
          // unused code: drop the word
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pen_x_r    <= '0;
      pen_y_r    <= '0;
      drawing_r  <= 1'b0;
      octant_r   <= OCT_0;
      walk_x_r   <= '0;
      walk_y_r   <= '0;
      end_x_r    <= '0;
      decision_r <= '0;
      straight_r <= '0;
      diagonal_r <= '0;
    end else begin
      pen_x_r    <= pen_x_nxt;
      pen_y_r    <= pen_y_nxt;
      drawing_r  <= drawing_nxt;
      octant_r   <= octant_nxt;
      walk_x_r   <= walk_x_nxt;
      walk_y_r   <= walk_y_nxt;
      end_x_r    <= end_x_nxt;
      decision_r <= decision_nxt;
      straight_r <= straight_nxt;
      diagonal_r <= diagonal_nxt;
    end
  end

  mlr_pixel_map #(
    .COORD_BITS (COORD_BITS)
  ) u_pixel_map (
    .octant   (octant_r),
    .walk_x   (walk_x_r),
    .walk_y   (walk_y_r),
    .center_x (center_x),
    .center_y (center_y),
    .pixel_x  (px_raw),
    .pixel_y  (py_raw)
  );

  // status of this word; a refusal carries zero pixel fields
  assign flags.valid      = fire && drawing_r && (is_tick || is_cmd);
  assign flags.last_pixel = is_tick && drawing_r && last_cond;
  assign flags.refused    = is_cmd && drawing_r;
  assign flags.drawing    = drawing_r;

  assign pixel_x = flags.refused ? '0 : px_raw;
  assign pixel_y = flags.refused ? '0 : py_raw;

endmodule
